### design/odc_pkg.sv
// Shared constants, the item type and a helper function of the offload decision cost model.
`default_nettype none
package odc_pkg;

   localparam int TIME_BITS = 40;
   localparam int FRAC_BITS = 16;

   localparam int SHW = FRAC_BITS + 1;
   localparam int K_SHIFT = FRAC_BITS + 8;
   localparam logic [SHW-1:0] SHARE_ONE = SHW'(1) << FRAC_BITS;

   // Divider datapath width covers the widest numerator and denominator.
   localparam int DIV_W_A = TIME_BITS + FRAC_BITS + 28;
   localparam int DIV_W_B = 64 + FRAC_BITS + 4;
   localparam int DIV_W = (DIV_W_A > DIV_W_B) ? DIV_W_A : DIV_W_B;
   localparam int DIV_QB = 25;
   localparam int DIV_IW = DIV_W + DIV_QB;

   localparam logic [23:0] SPD_MAX = 24'hFFFFFF;
   localparam logic [23:0] SPD_ONE = 24'd256;

   localparam logic [2:0] CSR_CLOCK_MHZ        = 3'd0;
   localparam logic [2:0] CSR_SYNC_COST_NS     = 3'd1;
   localparam logic [2:0] CSR_BATCH_FLOOR      = 3'd2;
   localparam logic [2:0] CSR_BATCH_CEILING    = 3'd3;
   localparam logic [2:0] CSR_DEPTH_CEILING    = 3'd4;
   localparam logic [2:0] CSR_PREFETCH_CEILING = 3'd5;
   localparam logic [2:0] CSR_FAR_LATENCY_NS   = 3'd6;
   localparam logic [2:0] CSR_NEAR_LATENCY_NS  = 3'd7;

   typedef struct packed {
      logic [TIME_BITS-1:0] h;
      logic [TIME_BITS-1:0] v;
      logic [63:0]          en_prod;
      logic                 e_zero;
      logic                 small_region;
      logic                 cb;
      logic                 frac_known;
      logic                 v_zero;
      logic                 blt;
      logic                 pflt;
      logic                 v_gt_h;
      logic                 h_zero;
      logic                 h_ge_v;
      logic [16:0]          batch;
      logic [7:0]           depth;
      logic [7:0]           pf;
      logic [SHW-1:0]       sh;
      logic [23:0]          cb_spd;
   } item_type;

   // Smallest power of two that is not below v, at least one and at most 2**17.
   function automatic logic [17:0] pow2_up(input logic [17:0] v);
      logic [17:0] p;
      p = 18'd1 << 17;
      for (int i = 17; i >= 0; i--) begin
         if (v <= (18'd1 << i)) p = 18'd1 << i;
      end
      return p;
   endfunction

endpackage
`default_nettype wire

### design/offload_decision_cost_model_unit.sv
// Top level of the offload decision cost model pipeline.
// Usage: one workload profile enters on the req_ channel and one decision
// leaves on the rsp_ channel. An item is taken at a clock edge with valid
// high and stall low. The block drives req_stall and watches rsp_stall.
// Configuration registers are written through csr_we, csr_index and
// csr_wdata while the block is idle; there is no read-back.
// The pipeline has two front stages of multiplies and adds, a 25-stage
// pipelined divider bank, four stages for result selection, the share
// product and overhead sum, a second 25-stage divider for the speedup, and
// the output register. Throughput is one item per cycle while the output
// is not stalled; each divider step is its own register stage.
// The whole pipeline advances together. While a result sits in the output
// register with rsp_stall high, every stage holds and req_stall is high;
// nothing is lost or repeated.
// Reset is synchronous and active high: it clears all valid bits and loads
// the configuration registers with their default values.
`default_nettype none
module offload_decision_cost_model_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [odc_pkg::TIME_BITS-1:0] req_host_work_ns,
   input  wire logic [odc_pkg::TIME_BITS-1:0] req_device_time_ns,
   input  wire logic [odc_pkg::TIME_BITS-1:0] req_stall_cycles,
   input  wire logic [odc_pkg::TIME_BITS-1:0] req_busy_cycles,
   input  wire logic [31:0]                   req_element_count,
   input  wire logic [31:0]                   req_host_elem_cost,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_should_offload,
   output logic      [16:0]                   rsp_host_share,
   output logic      [16:0]                   rsp_batch_size,
   output logic      [7:0]                    rsp_hop_depth,
   output logic      [7:0]                    rsp_prefetch_distance,
   output logic                               rsp_latency_hidden,
   output logic      [23:0]                   rsp_speedup_estimate,
   output logic      [6:0]                    rsp_reason_flags,
   input  wire logic                          csr_we,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [23:0]                   csr_wdata
);
   import odc_pkg::*;

   localparam int TW = TIME_BITS;

   // Configuration registers.
   logic [15:0] clock_mhz_ff, far_ff, near_ff;
   logic [23:0] sync_ff;
   logic [16:0] bfloor_ff, bceil_ff;
   logic [7:0]  dceil_ff, pceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_mhz_ff <= 16'd1000;
         sync_ff      <= 24'd1000;
         bfloor_ff    <= 17'd1;
         bceil_ff     <= 17'd4096;
         dceil_ff     <= 8'd8;
         pceil_ff     <= 8'd16;
         far_ff       <= 16'd300;
         near_ff      <= 16'd40;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLOCK_MHZ:        clock_mhz_ff <= csr_wdata[15:0];
            CSR_SYNC_COST_NS:     sync_ff      <= csr_wdata;
            CSR_BATCH_FLOOR:      bfloor_ff    <= csr_wdata[16:0];
            CSR_BATCH_CEILING:    bceil_ff     <= csr_wdata[16:0];
            CSR_DEPTH_CEILING:    dceil_ff     <= csr_wdata[7:0];
            CSR_PREFETCH_CEILING: pceil_ff     <= csr_wdata[7:0];
            CSR_FAR_LATENCY_NS:   far_ff       <= csr_wdata[15:0];
            CSR_NEAR_LATENCY_NS:  near_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: products.
   logic            s1_valid_ff;
   logic [TW-1:0]   h1_ff, v1_ff, s1_ff, c1_ff;
   logic [31:0]     e1_ff;
   logic [57:0]     x1_ff, x1_in;
   logic [TW+16:0]  bfv1_ff, bfv1_in;
   logic [TW+3:0]   s9_1_ff, s15_1_ff;
   logic [TW+9:0]   s1000_1_ff;
   logic [31:0]     d1_ff, d1_in;
   logic [63:0]     en1_ff, en1_in;
   logic [31:0]     n_eff;
   logic [15:0]     gap;

   always_comb begin
      n_eff   = (req_element_count == 32'd0) ? 32'd1 : req_element_count;
      gap     = (far_ff > near_ff) ? far_ff - near_ff : 16'd1;
      x1_in   = 58'({sync_ff, 2'b00}) * 58'(n_eff);
      bfv1_in = (TW+17)'(bfloor_ff) * (TW+17)'(req_device_time_ns);
      d1_in   = 32'(clock_mhz_ff) * 32'(gap);
      en1_in  = 64'(req_host_elem_cost) * 64'(n_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_ff      <= req_host_work_ns;
         v1_ff      <= req_device_time_ns;
         s1_ff      <= req_stall_cycles;
         c1_ff      <= req_busy_cycles;
         e1_ff      <= req_host_elem_cost;
         x1_ff      <= x1_in;
         bfv1_ff    <= bfv1_in;
         s9_1_ff    <= (TW+4)'(req_stall_cycles) * (TW+4)'(9);
         s15_1_ff   <= (TW+4)'(req_stall_cycles) * (TW+4)'(15);
         s1000_1_ff <= (TW+10)'(req_stall_cycles) * (TW+10)'(1000);
         d1_ff      <= d1_in;
         en1_ff     <= en1_in;
      end
   end

   // Stage 2: divider operands and early-exit tests.
   logic             s2_valid_ff;
   item_type         it2_ff, it2_in;
   logic [DIV_W-1:0] nb2_ff, db2_ff, nd2_ff, dd2_ff, np2_ff, dp2_ff;
   logic [DIV_W-1:0] ns2_ff, ds2_ff, ncb2_ff, dcb2_ff;
   logic [DIV_W-1:0] nb2_in, db2_in, nd2_in, dd2_in, np2_in, dp2_in;
   logic [DIV_W-1:0] ns2_in, ds2_in, ncb2_in, dcb2_in;
   logic [DIV_W-1:0] rn, rd;
   logic [TW:0]      sc;

   always_comb begin
      sc = (TW+1)'(s1_ff) + (TW+1)'(c1_ff);
      it2_in = '0;
      it2_in.h          = h1_ff;
      it2_in.v          = v1_ff;
      it2_in.en_prod    = en1_ff;
      it2_in.e_zero     = e1_ff == 32'd0;
      it2_in.small_region = ((TW+1)'(v1_ff) + (TW+1)'(sync_ff) >= (TW+1)'(h1_ff)) &&
                            ((TW+1)'(h1_ff) < (TW+1)'({sync_ff, 1'b0}));
      it2_in.frac_known = (clock_mhz_ff != 16'd0) && (sc != '0);
      it2_in.cb         = it2_in.frac_known && ((TW+4)'(s9_1_ff) < (TW+4)'(c1_ff)) &&
                          ((TW+2)'({v1_ff, 1'b0}) > (TW+2)'(h1_ff) * (TW+2)'(3));
      it2_in.v_zero     = v1_ff == '0;
      it2_in.blt        = (TW+58)'(x1_ff) < (TW+58)'(bfv1_ff);
      it2_in.pflt       = (TW+10)'(s1000_1_ff) < (TW+10)'({d1_ff, 2'b00});
      it2_in.v_gt_h     = v1_ff > h1_ff;
      it2_in.h_zero     = h1_ff == '0;
      it2_in.h_ge_v     = h1_ff >= v1_ff;

      nb2_in  = DIV_W'({x1_ff, 1'b0}) + DIV_W'(v1_ff);
      db2_in  = DIV_W'({v1_ff, 1'b0});
      nd2_in  = DIV_W'(s15_1_ff) + DIV_W'(c1_ff);
      dd2_in  = DIV_W'({sc, 1'b0});
      np2_in  = DIV_W'({s1000_1_ff, 1'b0}) + DIV_W'(d1_ff);
      dp2_in  = DIV_W'({d1_ff, 1'b0});
      if (e1_ff == 32'd0) begin
         rn = DIV_W'(v1_ff);
         rd = DIV_W'(h1_ff) + DIV_W'(v1_ff);
      end else begin
         rn = DIV_W'(v1_ff) << 8;
         rd = DIV_W'(en1_ff) + (DIV_W'(v1_ff) << 8);
      end
      ns2_in  = (rn << (FRAC_BITS + 1)) + rd;
      ds2_in  = rd << 1;
      ncb2_in = DIV_W'(v1_ff) << 8;
      dcb2_in = DIV_W'(h1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it2_ff  <= it2_in;
         nb2_ff  <= nb2_in;
         db2_ff  <= db2_in;
         nd2_ff  <= nd2_in;
         dd2_ff  <= dd2_in;
         np2_ff  <= np2_in;
         dp2_ff  <= dp2_in;
         ns2_ff  <= ns2_in;
         ds2_ff  <= ds2_in;
         ncb2_ff <= ncb2_in;
         dcb2_ff <= dcb2_in;
      end
   end

   // First divider bank.
   logic [DIV_QB-1:0] qb, qd, qp, qs, qcb, qspd;
   logic              d1_valid;
   item_type          d1_item;

   odc_div u_div_batch (.clock(clock), .en(adv), .num(nb2_ff), .den(db2_ff), .quo(qb));
   odc_div u_div_depth (.clock(clock), .en(adv), .num(nd2_ff), .den(dd2_ff), .quo(qd));
   odc_div u_div_pf    (.clock(clock), .en(adv), .num(np2_ff), .den(dp2_ff), .quo(qp));
   odc_div u_div_share (.clock(clock), .en(adv), .num(ns2_ff), .den(ds2_ff), .quo(qs));
   odc_div u_div_cb    (.clock(clock), .en(adv), .num(ncb2_ff), .den(dcb2_ff), .quo(qcb));

   odc_delay u_delay_a (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(s2_valid_ff), .in_item(it2_ff),
      .out_valid(d1_valid), .out_item(d1_item)
   );

   // Stage 3: power-of-two batch, depth, prefetch, share quantization, speedup clamp.
   logic        s3_valid_ff;
   item_type    it3_ff, it3_in;
   logic [16:0] batch0;
   logic [17:0] bpow;
   logic [3:0]  dep0;

   always_comb begin
      it3_in = d1_item;
      if (d1_item.v_zero)
         batch0 = (bfloor_ff < bceil_ff) ? bfloor_ff : bceil_ff;
      else if (d1_item.blt)
         batch0 = bfloor_ff;
      else
         batch0 = (qb < DIV_QB'(bceil_ff)) ? qb[16:0] : bceil_ff;
      bpow = pow2_up(18'(batch0));
      it3_in.batch = (bpow < 18'(bceil_ff)) ? bpow[16:0] : bceil_ff;

      dep0 = d1_item.frac_known ? 4'(qd[2:0]) + 4'd1 : 4'd5;
      it3_in.depth = (8'(dep0) < dceil_ff) ? 8'(dep0) : dceil_ff;

      if (clock_mhz_ff == 16'd0 || d1_item.pflt)
         it3_in.pf = 8'd4;
      else
         it3_in.pf = (qp < DIV_QB'(pceil_ff)) ? qp[7:0] : pceil_ff;

      if (d1_item.v_gt_h)
         it3_in.sh = (qs > DIV_QB'(SHARE_ONE)) ? SHARE_ONE : qs[SHW-1:0];
      else
         it3_in.sh = '0;

      if (d1_item.h_zero)
         it3_in.cb_spd = SPD_ONE;
      else
         it3_in.cb_spd = (qcb > DIV_QB'(SPD_MAX)) ? SPD_MAX : qcb[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= d1_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) it3_ff <= it3_in;
   end

   // Stage 4: share products, the element product split in two halves.
   logic                s4_valid_ff;
   item_type            it4_ff;
   logic [TW+SHW-1:0]   pv4_ff, ph4_ff;
   logic [32+SHW-1:0]   plo4_ff, phi4_ff;
   logic [SHW-1:0]      one_minus;

   assign one_minus = SHARE_ONE - it3_ff.sh;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it4_ff  <= it3_ff;
         pv4_ff  <= (TW+SHW)'(it3_ff.v) * (TW+SHW)'(one_minus);
         ph4_ff  <= (TW+SHW)'(it3_ff.h) * (TW+SHW)'(it3_ff.sh);
         plo4_ff <= (32+SHW)'(it3_ff.en_prod[31:0]) * (32+SHW)'(it3_ff.sh);
         phi4_ff <= (32+SHW)'(it3_ff.en_prod[63:32]) * (32+SHW)'(it3_ff.sh);
      end
   end

   // Stage 5: blended device-side time.
   logic             s5_valid_ff;
   item_type         it5_ff;
   logic [DIV_W-1:0] num5_ff, num5_in;

   always_comb begin
      if (it4_ff.e_zero)
         num5_in = (DIV_W'(pv4_ff) << 8) + (DIV_W'(ph4_ff) << 8);
      else
         num5_in = (DIV_W'(pv4_ff) << 8) + (DIV_W'(phi4_ff) << 32) + DIV_W'(plo4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (adv) s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it5_ff  <= it4_ff;
         num5_ff <= num5_in;
      end
   end

   // Stage 6: offload time with sync cost, lower bound of one.
   logic             s6_valid_ff;
   item_type         it6_ff;
   logic [DIV_W-1:0] ov6_ff, ov6_in, nspd6_ff, nspd6_in;
   logic [DIV_W-1:0] hk, numv;

   always_comb begin
      hk     = DIV_W'(it5_ff.h) << K_SHIFT;
      numv   = (num5_ff > hk) ? num5_ff : hk;
      ov6_in = numv + (DIV_W'(sync_ff) << K_SHIFT);
      if (ov6_in < (DIV_W'(1) << K_SHIFT)) ov6_in = DIV_W'(1) << K_SHIFT;
      nspd6_in = (DIV_W'(it5_ff.h) + DIV_W'(sync_ff)) << (K_SHIFT + 8);
   end

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else if (adv) s6_valid_ff <= s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it6_ff   <= it5_ff;
         ov6_ff   <= ov6_in;
         nspd6_ff <= nspd6_in;
      end
   end

   // Speedup divider.
   logic     d2_valid;
   item_type d2_item;

   odc_div u_div_spd (.clock(clock), .en(adv), .num(nspd6_ff), .den(ov6_ff), .quo(qspd));

   odc_delay u_delay_b (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(s6_valid_ff), .in_item(it6_ff),
      .out_valid(d2_valid), .out_item(d2_item)
   );

   // Final selection, limit clamp and output register.
   logic        off_in, hid_in, clamped;
   logic [16:0] sh_in, batch_in;
   logic [7:0]  depth_in, pf_in;
   logic [23:0] spd_in;
   logic [6:0]  fl_in;

   logic        off_ff, hid_ff;
   logic [16:0] sh_ff, batch_ff;
   logic [7:0]  depth_ff, pf_ff;
   logic [23:0] spd_ff;
   logic [6:0]  fl_ff;

   always_comb begin
      if (d2_item.small_region || d2_item.cb) begin
         off_in   = 1'b0;
         sh_in    = 17'(SHARE_ONE);
         batch_in = bfloor_ff;
         depth_in = 8'd1;
         pf_in    = 8'd0;
         if (d2_item.small_region) begin
            hid_in = 1'b1;
            spd_in = SPD_ONE;
            fl_in  = 7'b000_0001;
         end else begin
            hid_in = d2_item.h_ge_v;
            spd_in = d2_item.cb_spd;
            fl_in  = 7'b000_0010;
         end
      end else begin
         off_in   = 1'b1;
         sh_in    = 17'(d2_item.sh);
         batch_in = d2_item.batch;
         depth_in = d2_item.depth;
         pf_in    = d2_item.pf;
         hid_in   = d2_item.h_ge_v;
         spd_in   = (qspd > DIV_QB'(SPD_MAX)) ? SPD_MAX : qspd[23:0];
         fl_in    = 7'b000_0100;
         if (d2_item.depth >= 8'd4) fl_in[3] = 1'b1;
         if (d2_item.v_gt_h) fl_in[4] = 1'b1;
         if (d2_item.h_ge_v) fl_in[5] = 1'b1;
      end

      clamped = 1'b0;
      if (batch_in < bfloor_ff) begin
         batch_in = bfloor_ff;
         clamped  = 1'b1;
      end
      if (batch_in > bceil_ff) begin
         batch_in = bceil_ff;
         clamped  = 1'b1;
      end
      if (depth_in == 8'd0) begin
         depth_in = 8'd1;
         clamped  = 1'b1;
      end
      if (depth_in > dceil_ff) begin
         depth_in = dceil_ff;
         clamped  = 1'b1;
      end
      if (pf_in > pceil_ff) begin
         pf_in   = pceil_ff;
         clamped = 1'b1;
      end
      if (clamped) fl_in[6] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= d2_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff   <= off_in;
         sh_ff    <= sh_in;
         batch_ff <= batch_in;
         depth_ff <= depth_in;
         pf_ff    <= pf_in;
         hid_ff   <= hid_in;
         spd_ff   <= spd_in;
         fl_ff    <= fl_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_should_offload    = off_ff;
   assign rsp_host_share        = sh_ff;
   assign rsp_batch_size        = batch_ff;
   assign rsp_hop_depth         = depth_ff;
   assign rsp_prefetch_distance = pf_ff;
   assign rsp_latency_hidden    = hid_ff;
   assign rsp_speedup_estimate  = spd_ff;
   assign rsp_reason_flags      = fl_ff;

   a_offload_batch_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_should_offload == rsp_reason_flags[2]))
      else $error("offload flag and batch reason disagree");

   a_host_keeps_all: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_should_offload |-> (rsp_host_share == 17'(SHARE_ONE)))
      else $error("no-offload decision without full host share");

   a_hidden_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_should_offload |-> (rsp_latency_hidden == rsp_reason_flags[5]))
      else $error("hidden flag and reason bit disagree");

   a_batch_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_batch_size <= bceil_ff))
      else $error("batch size above ceiling");

endmodule
`default_nettype wire

### design/odc_div.sv
// Pipelined restoring divider with a saturating quotient, one bit per stage.
`default_nettype none
module odc_div (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [odc_pkg::DIV_W-1:0]  num,
   input  wire logic [odc_pkg::DIV_W-1:0]  den,
   output logic      [odc_pkg::DIV_QB-1:0] quo
);
   import odc_pkg::*;

   logic [DIV_IW-1:0] rem_ff [DIV_QB-1];
   logic [DIV_IW-1:0] rem_in [DIV_QB-1];
   logic [DIV_W-1:0]  den_ff [DIV_QB-1];
   logic [DIV_QB-1:0] q_ff   [DIV_QB];
   logic [DIV_QB-1:0] q_in   [DIV_QB];
   logic              sat_ff [DIV_QB];

   genvar s;
   for (s = 0; s < DIV_QB; s++) begin : g_stage
      logic [DIV_IW-1:0] r_src;
      logic [DIV_IW-1:0] d_sh;
      logic [DIV_W-1:0]  d_src;
      logic [DIV_QB-1:0] q_src;
      logic              sat_src;
      logic              ge;

      if (s == 0) begin : g_first
         // A quotient that does not fit in the stage count saturates.
         assign r_src   = DIV_IW'(num);
         assign d_src   = den;
         assign q_src   = '0;
         assign sat_src = DIV_IW'(num) >= (DIV_IW'(den) << DIV_QB);
      end else begin : g_next
         assign r_src   = rem_ff[s-1];
         assign d_src   = den_ff[s-1];
         assign q_src   = q_ff[s-1];
         assign sat_src = sat_ff[s-1];
      end

      assign d_sh    = DIV_IW'(d_src) << (DIV_QB - 1 - s);
      assign ge      = r_src >= d_sh;
      assign q_in[s] = ge ? (q_src | (DIV_QB'(1) << (DIV_QB - 1 - s))) : q_src;

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s]   <= q_in[s];
            sat_ff[s] <= sat_src;
         end
      end

      if (s < DIV_QB - 1) begin : g_carry
         assign rem_in[s] = ge ? r_src - d_sh : r_src;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in[s];
               den_ff[s] <= d_src;
            end
         end
      end
   end

   assign quo = sat_ff[DIV_QB-1] ? '1 : q_ff[DIV_QB-1];

endmodule
`default_nettype wire

### design/odc_delay.sv
// Delay line that carries an item and its valid bit alongside a divider.
`default_nettype none
module odc_delay (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire odc_pkg::item_type in_item,
   output logic                   out_valid,
   output odc_pkg::item_type      out_item
);
   import odc_pkg::*;

   logic     valid_ff [DIV_QB];
   item_type item_ff  [DIV_QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_QB; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DIV_QB; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= in_item;
         for (int i = 1; i < DIV_QB; i++) item_ff[i] <= item_ff[i-1];
      end
   end

   assign out_valid = valid_ff[DIV_QB-1];
   assign out_item  = item_ff[DIV_QB-1];

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the offload decision cost model unit.
`default_nettype none
module tb_top;
   import odc_pkg::*;

   typedef struct {
      logic [39:0] h, v, s, c;
      logic [31:0] n, e;
   } profile_type;

   typedef struct {
      logic        off;
      logic [16:0] sh;
      logic [16:0] batch;
      logic [7:0]  depth;
      logic [7:0]  pf;
      logic        hid;
      logic [23:0] spd;
      logic [6:0]  fl;
   } decision_type;

   typedef struct {
      profile_type  p;
      bit           known;
      decision_type d;
   } row_type;

   typedef bit [191:0] wide_type;

   localparam logic [39:0] T_MAX = 40'hFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 3000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [39:0] req_host_work_ns = 0, req_device_time_ns = 0;
   logic [39:0] req_stall_cycles = 0, req_busy_cycles = 0;
   logic [31:0] req_element_count = 0, req_host_elem_cost = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_should_offload, rsp_latency_hidden;
   logic [16:0] rsp_host_share, rsp_batch_size;
   logic [7:0] rsp_hop_depth, rsp_prefetch_distance;
   logic [23:0] rsp_speedup_estimate;
   logic [6:0] rsp_reason_flags;
   logic csr_we = 0;
   logic [2:0] csr_index = 0;
   logic [23:0] csr_wdata = 0;

   // Shadow copy of the configuration registers.
   logic [15:0] cfg_clock_mhz, cfg_far_ns, cfg_near_ns;
   logic [23:0] cfg_sync_ns;
   logic [16:0] cfg_batch_floor, cfg_batch_ceiling;
   logic [7:0]  cfg_depth_ceiling, cfg_prefetch_ceiling;

   decision_type decisions_due[$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned draw;
   bit quiet = 0;
   bit rsp_take = 0;
   bit req_take;

   offload_decision_cost_model_unit i_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic wide_type wmin(wide_type a, wide_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic decision_type decide(profile_type p);
      wide_type h, v, s, c, n, e, sy, sc, x, g, dd, rn, rd, num, ov;
      wide_type batch, depth, pf, sh, spd, one, pw;
      logic fk, hid, off;
      logic [6:0] fl;
      decision_type d;
      h = wide_type'(p.h); v = wide_type'(p.v); s = wide_type'(p.s);
      c = wide_type'(p.c); e = wide_type'(p.e);
      n = (p.n == 32'd0) ? wide_type'(1) : wide_type'(p.n);
      sy = wide_type'(cfg_sync_ns);
      sc = s + c;
      one = wide_type'(1) << FRAC_BITS;
      fk = (cfg_clock_mhz != 16'd0) && (sc != 0);
      fl = '0;
      if (v + sy >= h && h < 2 * sy) begin
         off = 1'b0; sh = one; batch = wide_type'(cfg_batch_floor); depth = 1; pf = 0;
         hid = 1'b1; spd = 256; fl = 7'h01;
      end else if (fk && s * 9 < c && v * 2 > h * 3) begin
         off = 1'b0; sh = one; batch = wide_type'(cfg_batch_floor); depth = 1; pf = 0;
         hid = (h >= v);
         spd = (h == 0) ? wide_type'(256) : wmin((v << 8) / h, wide_type'(24'hFFFFFF));
         fl = 7'h02;
      end else begin
         off = 1'b1;
         if (v == 0) begin
            batch = wmin(wide_type'(cfg_batch_floor), wide_type'(cfg_batch_ceiling));
         end else begin
            x = 4 * sy * n;
            if (x < wide_type'(cfg_batch_floor) * v) batch = wide_type'(cfg_batch_floor);
            else batch = wmin(((x << 1) + v) / (v * 2), wide_type'(cfg_batch_ceiling));
         end
         pw = 1;
         while (pw < batch) pw = pw << 1;
         batch = wmin(pw, wide_type'(cfg_batch_ceiling));
         fl |= 7'h04;

         if (!fk) depth = 5;
         else depth = 1 + (s * 15 + c) / (sc << 1);
         depth = wmin(depth, wide_type'(cfg_depth_ceiling));
         if (depth >= 4) fl |= 7'h08;

         if (cfg_clock_mhz == 16'd0) begin
            pf = 4;
         end else begin
            g = (wide_type'(cfg_far_ns) > wide_type'(cfg_near_ns) + 1) ?
                wide_type'(cfg_far_ns) - wide_type'(cfg_near_ns) : wide_type'(1);
            dd = wide_type'(cfg_clock_mhz) * g;
            if (s * 1000 < dd * 4) pf = 4;
            else pf = wmin((s * 2000 + dd) / (dd * 2), wide_type'(cfg_prefetch_ceiling));
         end

         sh = 0;
         if (v > h) begin
            if (e == 0) begin
               rn = v; rd = h + v;
            end else begin
               rn = v * 256; rd = e * n + v * 256;
            end
            sh = ((rn << (FRAC_BITS + 1)) + rd) / (rd << 1);
            if (sh > one) sh = one;
            fl |= 7'h10;
         end

         num = (v * (one - sh)) << 8;
         if (e != 0) num = num + e * n * sh;
         else num = num + ((h * sh) << 8);
         ov = h << K_SHIFT;
         if (num > ov) ov = num;
         ov = ov + (sy << K_SHIFT);
         if (ov < (wide_type'(1) << K_SHIFT)) ov = wide_type'(1) << K_SHIFT;
         spd = wmin(((h + sy) << (K_SHIFT + 8)) / ov, wide_type'(24'hFFFFFF));
         hid = (h >= v);
         if (hid) fl |= 7'h20;
      end

      // The hardware limits are applied last, in a fixed order.
      if (batch < wide_type'(cfg_batch_floor)) begin
         batch = wide_type'(cfg_batch_floor); fl |= 7'h40;
      end
      if (batch > wide_type'(cfg_batch_ceiling)) begin
         batch = wide_type'(cfg_batch_ceiling); fl |= 7'h40;
      end
      if (depth < 1) begin depth = 1; fl |= 7'h40; end
      if (depth > wide_type'(cfg_depth_ceiling)) begin
         depth = wide_type'(cfg_depth_ceiling); fl |= 7'h40;
      end
      if (pf > wide_type'(cfg_prefetch_ceiling)) begin
         pf = wide_type'(cfg_prefetch_ceiling); fl |= 7'h40;
      end

      d.off = off; d.sh = sh[16:0]; d.batch = batch[16:0]; d.depth = depth[7:0];
      d.pf = pf[7:0]; d.hid = hid; d.spd = spd[23:0]; d.fl = fl;
      return d;
   endfunction

   function automatic void reset_config();
      cfg_clock_mhz = 16'd1000; cfg_sync_ns = 24'd1000; cfg_batch_floor = 17'd1;
      cfg_batch_ceiling = 17'd4096; cfg_depth_ceiling = 8'd8; cfg_prefetch_ceiling = 8'd16;
      cfg_far_ns = 16'd300; cfg_near_ns = 16'd40;
   endfunction

   // Leaves the write enable high; the caller drops it after the last write.
   task automatic csr_write(logic [2:0] idx, logic [23:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_CLOCK_MHZ:        cfg_clock_mhz = data[15:0];
         CSR_SYNC_COST_NS:     cfg_sync_ns = data;
         CSR_BATCH_FLOOR:      cfg_batch_floor = data[16:0];
         CSR_BATCH_CEILING:    cfg_batch_ceiling = data[16:0];
         CSR_DEPTH_CEILING:    cfg_depth_ceiling = data[7:0];
         CSR_PREFETCH_CEILING: cfg_prefetch_ceiling = data[7:0];
         CSR_FAR_LATENCY_NS:   cfg_far_ns = data[15:0];
         CSR_NEAR_LATENCY_NS:  cfg_near_ns = data[15:0];
         default: ;
      endcase
   endtask

   // Entered and left at a rising edge; the handshake is sampled at the falling edge.
   task automatic offer(profile_type p, bit known, decision_type d);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_host_work_ns <= p.h;
      req_device_time_ns <= p.v;
      req_stall_cycles <= p.s;
      req_busy_cycles <= p.c;
      req_element_count <= p.n;
      req_host_elem_cost <= p.e;
      do @(negedge clock); while (req_stall);
      decisions_due.push_back(known ? d : decide(p));
      @(posedge clock);
   endtask

   function automatic logic [39:0] rand_time();
      case ($urandom_range(0, 4))
         0: return 40'({$urandom, $urandom});
         1: return 40'($urandom_range(0, 5000));
         2: return 40'($urandom_range(0, 1 << 22));
         3: return {8'($urandom_range(0, 255)), 32'($urandom)};
         default: return $urandom_range(0, 1) ? T_MAX : 40'd0;
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 4))
         0, 1: return 32'd0;
         2: return 32'($urandom_range(1, 2000));
         3: return 32'($urandom);
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic profile_type rand_profile();
      profile_type p;
      p.h = rand_time(); p.v = rand_time();
      p.s = rand_time(); p.c = rand_time();
      p.n = rand_word(); p.e = rand_word();
      return p;
   endfunction

   task automatic drain();
      while (decisions_due.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic random_items(int unsigned count);
      decision_type none;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
         offer(rand_profile(), 0, none);
      end
      req_valid <= 0;
      @(posedge clock);
   endtask

   // Handshake sampling, result checking and the watchdog.
   always @(negedge clock) begin
      decision_type want;
      rsp_take = !reset && rsp_valid && !rsp_stall;
      req_take = !reset && req_valid && !req_stall;
      if (rsp_take) begin
         if (decisions_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected decision item");
         end else begin
            want = decisions_due.pop_front();
            if (rsp_should_offload !== want.off || rsp_host_share !== want.sh ||
                rsp_batch_size !== want.batch || rsp_hop_depth !== want.depth ||
                rsp_prefetch_distance !== want.pf || rsp_latency_hidden !== want.hid ||
                rsp_speedup_estimate !== want.spd || rsp_reason_flags !== want.fl) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp off=%0d sh=%0d b=%0d d=%0d pf=%0d hid=%0d spd=%0d fl=%h",
                           want.off, want.sh, want.batch, want.depth, want.pf, want.hid,
                           want.spd, want.fl, "\n          got off=%0d sh=%0d b=%0d d=%0d ",
                           rsp_should_offload, rsp_host_share, rsp_batch_size,
                           rsp_hop_depth, "pf=%0d hid=%0d spd=%0d fl=%h",
                           rsp_prefetch_distance, rsp_latency_hidden,
                           rsp_speedup_estimate, rsp_reason_flags);
            end
         end
      end
      if (rsp_take || req_take || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Result side: random stalls after each item, plus one long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (rsp_take) begin
         draw = quiet ? 0 : $urandom_range(0, 13);
         stall_left = (draw > 0) ? draw - 1 : 0;
         rsp_stall <= (draw > 0);
      end else begin
         rsp_stall <= 0;
      end
   end

   initial begin
      row_type rows[10];
      decision_type small_zero, cb_row;
      logic [23:0] wdata;
      small_zero = '{1'b0, 17'd65536, 17'd1, 8'd1, 8'd0, 1'b1, 24'd256, 7'h01};
      cb_row = '{1'b0, 17'd65536, 17'd1, 8'd1, 8'd0, 1'b0, 24'd512, 7'h02};
      rows[0] = '{'{40'd0, 40'd0, 40'd0, 40'd0, 32'd0, 32'd0}, 1, small_zero};
      rows[1] = '{'{40'd4000, 40'd8000, 40'd0, 40'd100, 32'd1, 32'd0}, 1, cb_row};
      rows[2] = '{'{T_MAX, T_MAX, T_MAX, T_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, cb_row};
      rows[3] = '{'{T_MAX, 40'd0, T_MAX, 40'd0, 32'd0, 32'd0}, 0, cb_row};
      rows[4] = '{'{40'd0, T_MAX, 40'd0, 40'd0, 32'd1, 32'd0}, 0, cb_row};
      rows[5] = '{'{40'd5000, 40'd9000, 40'd500, 40'd500, 32'd100, 32'd0}, 0, cb_row};
      rows[6] = '{'{40'd5000, 40'd9000, 40'd500, 40'd500, 32'd100, 32'h100}, 0, cb_row};
      rows[7] = '{'{40'd10000, 40'd3000, 40'd1000, 40'd9000, 32'd1000, 32'd0}, 0, cb_row};
      rows[8] = '{'{40'd3000, 40'd4000, T_MAX, 40'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                  0, cb_row};
      rows[9] = '{'{40'd2000, 40'd100000, 40'd7, 40'd1, 32'd0, 32'd1}, 0, cb_row};

      reset_config();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) offer(rows[i].p, rows[i].known, rows[i].d);
      req_valid <= 0;
      @(posedge clock);

      // Hold the result side off for a long stretch while items keep being offered.
      hold_left = 400;
      random_items(180);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < 8; r++) begin
            case (ph)
               0: wdata = (r == 2 || r == 3) ? 24'd65536 : 24'hFFFFFF;
               1: wdata = '0;
               2: wdata = (r == 2) ? 24'd65536 : (r == 3) ? 24'd16 : 24'($urandom);
               default: begin
                  case (r)
                     0: wdata = 24'($urandom_range(0, 3000));
                     1: wdata = 24'($urandom_range(0, 20000));
                     2: wdata = 24'($urandom_range(0, 64));
                     3: wdata = 24'($urandom_range(0, 65536));
                     4, 5: wdata = 24'($urandom_range(0, 255));
                     default: wdata = 24'($urandom_range(0, 1000));
                  endcase
               end
            endcase
            csr_write(3'(r), wdata);
         end
         csr_we <= 1'b0;
         random_items(155);
         drain();
      end

      if (mismatches == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
design/odc_pkg.sv
design/odc_div.sv
design/odc_delay.sv
design/offload_decision_cost_model_unit.sv
sim/tb_top.sv
